@@ src/hrsm_pkg.sv @@
// ============================================================================
// hrsm_pkg
// Shared types and constants for the heart rate slot monitor.
// ============================================================================
`default_nettype none

package hrsm_pkg;

    localparam int TIME_W = 32;
    localparam int RATE_W = 16;
    localparam int SLOT_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_LINK_UP = 2'd2;
    localparam logic [1:0] OP_LINK_DOWN = 2'd3;

    localparam logic [7:0] FLAG_WIDE = 8'h01;
    localparam logic [7:0] FLAG_CONTACT = 8'h02;
    localparam logic [7:0] FLAG_SUPPORTED = 8'h04;

    localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_TIMEOUT = 2'd1;

    localparam logic [TIME_W-1:0] STALE_TIMEOUT_RESET = 32'd3000;
    localparam logic [TIME_W-1:0] STUCK_TIMEOUT_RESET = 32'd15000;

    typedef struct packed {
        logic load;
        logic exec;
    } hrsm_cmd_t;

endpackage

`default_nettype wire

@@ src/hrsm_ctrl.sv @@
// ============================================================================
// hrsm_ctrl
// Sequencer: capture a word, run the slot update, strobe the result.
// ============================================================================
`default_nettype none

module hrsm_ctrl
    import hrsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    output logic            done,
    output hrsm_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        unique case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = (state_reg == ST_DONE);

    // accepted word goes to execution next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not enter execution");

    // execution always ends in one result strobe
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("execution did not produce a result");

    // a strobe lasts one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // load and exec never issued together
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.exec))
        else $error("load and exec issued together");

endmodule

`default_nettype wire

@@ src/hrsm_datapath.sv @@
// ============================================================================
// hrsm_datapath
// Slot records, timeout registers, measurement decode and freshness check.
// ============================================================================
`default_nettype none

module hrsm_datapath
    import hrsm_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hrsm_cmd_t            cmd,
    input  wire logic [1:0]           op,
    input  wire logic [SLOT_W-1:0]    slot,
    input  wire logic [7:0]           payload_length,
    input  wire logic [7:0]           flags_byte,
    input  wire logic [7:0]           rate_low,
    input  wire logic [7:0]           rate_high,
    input  wire logic [TIME_W-1:0]    now_ms,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]    cfg_data,
    output logic [SLOT_W-1:0]         slot_out,
    output logic [RATE_W-1:0]         heart_rate,
    output logic                      contact,
    output logic                      contact_supported,
    output logic                      linked,
    output logic                      fresh,
    output logic                      sample_taken
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // captured word
    logic [1:0]        op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [7:0]        len_reg;
    logic [7:0]        flags_reg;
    logic [7:0]        lo_reg;
    logic [7:0]        hi_reg;
    logic [TIME_W-1:0] now_reg;

    // timeout registers
    logic [TIME_W-1:0] stale_timeout_reg;
    logic [TIME_W-1:0] stuck_timeout_reg;

    // slot records
    logic [RATE_W-1:0] rate_store_reg [SLOTS];
    logic              contact_store_reg [SLOTS];
    logic              supported_store_reg [SLOTS];
    logic              link_store_reg [SLOTS];
    logic              sample_valid_store_reg [SLOTS];
    logic [TIME_W-1:0] sample_time_store_reg [SLOTS];
    logic              change_valid_store_reg [SLOTS];
    logic [RATE_W-1:0] distinct_rate_store_reg [SLOTS];
    logic [TIME_W-1:0] change_time_store_reg [SLOTS];

    // result word
    logic [SLOT_W-1:0] slot_out_reg;
    logic [RATE_W-1:0] rate_out_reg;
    logic              contact_out_reg;
    logic              supported_out_reg;
    logic              linked_out_reg;
    logic              fresh_out_reg;
    logic              taken_out_reg;

    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic              wide;
    logic              len_ok;
    logic [RATE_W-1:0] rate_dec;
    logic              sup_dec;

    logic [RATE_W-1:0] rate_next;
    logic              contact_next;
    logic              supported_next;
    logic              link_next;
    logic              sample_valid_next;
    logic [TIME_W-1:0] sample_time_next;
    logic              change_valid_next;
    logic [RATE_W-1:0] distinct_rate_next;
    logic [TIME_W-1:0] change_time_next;
    logic              taken_next;
    logic [TIME_W-1:0] sample_age;
    logic [TIME_W-1:0] change_age;
    logic              fresh_next;

    assign idx = IDX_W'(slot_reg);
    assign in_range = (32'(slot_reg) < SLOTS);
    assign wide = ((flags_reg & FLAG_WIDE) != 8'h00);
    assign sup_dec = ((flags_reg & FLAG_SUPPORTED) != 8'h00);
    assign len_ok = (len_reg >= 8'd2) && (!wide || (len_reg >= 8'd3));
    assign rate_dec = wide ? {hi_reg, lo_reg} : {8'h00, lo_reg};

    always_comb
    begin
        rate_next = rate_store_reg[idx];
        contact_next = contact_store_reg[idx];
        supported_next = supported_store_reg[idx];
        link_next = link_store_reg[idx];
        sample_valid_next = sample_valid_store_reg[idx];
        sample_time_next = sample_time_store_reg[idx];
        change_valid_next = change_valid_store_reg[idx];
        distinct_rate_next = distinct_rate_store_reg[idx];
        change_time_next = change_time_store_reg[idx];
        taken_next = 1'b0;
        unique case (op_reg)
            OP_MEASURE:
            begin
                if (len_ok)
                begin
                    rate_next = rate_dec;
                    supported_next = sup_dec;
                    contact_next = sup_dec && ((flags_reg & FLAG_CONTACT) != 8'h00);
                    sample_valid_next = 1'b1;
                    sample_time_next = now_reg;
                    if (!change_valid_store_reg[idx]
                        || (distinct_rate_store_reg[idx] != rate_dec))
                    begin
                        change_valid_next = 1'b1;
                        distinct_rate_next = rate_dec;
                        change_time_next = now_reg;
                    end
                    taken_next = 1'b1;
                end
            end
            OP_LINK_UP:
            begin
                link_next = 1'b1;
            end
            OP_LINK_DOWN:
            begin
                link_next = 1'b0;
                sample_valid_next = 1'b0;
                sample_time_next = '0;
                change_valid_next = 1'b0;
                distinct_rate_next = '0;
                change_time_next = '0;
            end
            OP_QUERY:
            begin
                taken_next = 1'b0;
            end
            default:
            begin
                taken_next = 1'b0;
            end
        endcase
    end

    assign sample_age = now_reg - sample_time_next;
    assign change_age = now_reg - change_time_next;
    assign fresh_next = link_next && sample_valid_next
                        && (sample_age <= stale_timeout_reg)
                        && !(supported_next && !contact_next)
                        && !(change_valid_next && (change_age > stuck_timeout_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            slot_reg <= slot;
            len_reg <= payload_length;
            flags_reg <= flags_byte;
            lo_reg <= rate_low;
            hi_reg <= rate_high;
            now_reg <= now_ms;
        end
        if (cmd.exec)
        begin
            slot_out_reg <= slot_reg;
            rate_out_reg <= in_range ? rate_next : '0;
            contact_out_reg <= in_range && contact_next;
            supported_out_reg <= in_range && supported_next;
            linked_out_reg <= in_range && link_next;
            fresh_out_reg <= in_range && fresh_next;
            taken_out_reg <= in_range && taken_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_timeout_reg <= STALE_TIMEOUT_RESET;
            stuck_timeout_reg <= STUCK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_STALE_TIMEOUT)
            begin
                stale_timeout_reg <= cfg_data;
            end
            else if (cfg_index == REG_STUCK_TIMEOUT)
            begin
                stuck_timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                rate_store_reg[i] <= '0;
                contact_store_reg[i] <= 1'b0;
                supported_store_reg[i] <= 1'b0;
                link_store_reg[i] <= 1'b0;
                sample_valid_store_reg[i] <= 1'b0;
                sample_time_store_reg[i] <= '0;
                change_valid_store_reg[i] <= 1'b0;
                distinct_rate_store_reg[i] <= '0;
                change_time_store_reg[i] <= '0;
            end
        end
        else if (cmd.exec && in_range)
        begin
            rate_store_reg[idx] <= rate_next;
            contact_store_reg[idx] <= contact_next;
            supported_store_reg[idx] <= supported_next;
            link_store_reg[idx] <= link_next;
            sample_valid_store_reg[idx] <= sample_valid_next;
            sample_time_store_reg[idx] <= sample_time_next;
            change_valid_store_reg[idx] <= change_valid_next;
            distinct_rate_store_reg[idx] <= distinct_rate_next;
            change_time_store_reg[idx] <= change_time_next;
        end
    end

    assign slot_out = slot_out_reg;
    assign heart_rate = rate_out_reg;
    assign contact = contact_out_reg;
    assign contact_supported = supported_out_reg;
    assign linked = linked_out_reg;
    assign fresh = fresh_out_reg;
    assign sample_taken = taken_out_reg;

endmodule

`default_nettype wire

@@ src/heart_rate_slot_monitor_top.sv @@
// ============================================================================
// heart_rate_slot_monitor_top
// Per-slot heart rate measurement monitor with link and freshness tracking.
//
// Command channel: a word is taken at a rising edge with start high and busy
// low. Fields: op, slot, payload_length, flags_byte, rate_low, rate_high,
// now_ms.
// Result channel: done is high for exactly one cycle with slot_out,
// heart_rate, contact, contact_supported, linked, fresh and sample_taken.
// One result per word: the word is captured at the accepting edge, then busy
// is high only in the update cycle, in which the addressed slot record is read,
// modified and written back; the result is registered and shown with done.
// No word is taken while busy; a new word may be taken while done is shown.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0
// is the stale timeout, index 1 the stuck timeout; other indexes are dropped.
// cfg_ready is always high.
// Reset: all slot records clear, timeouts return to 3000 and 15000 ms.
// The receiver cannot stall: results are shown for one cycle only.
// ============================================================================
`default_nettype none

module heart_rate_slot_monitor_top
    import hrsm_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           op,
    input  wire logic [SLOT_W-1:0]    slot,
    input  wire logic [7:0]           payload_length,
    input  wire logic [7:0]           flags_byte,
    input  wire logic [7:0]           rate_low,
    input  wire logic [7:0]           rate_high,
    input  wire logic [TIME_W-1:0]    now_ms,
    output logic                      done,
    output logic [SLOT_W-1:0]         slot_out,
    output logic [RATE_W-1:0]         heart_rate,
    output logic                      contact,
    output logic                      contact_supported,
    output logic                      linked,
    output logic                      fresh,
    output logic                      sample_taken,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]    cfg_data
);

    hrsm_cmd_t cmd;

    assign cfg_ready = 1'b1;

    hrsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    hrsm_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .op                (op),
        .slot              (slot),
        .payload_length    (payload_length),
        .flags_byte        (flags_byte),
        .rate_low          (rate_low),
        .rate_high         (rate_high),
        .now_ms            (now_ms),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .slot_out          (slot_out),
        .heart_rate        (heart_rate),
        .contact           (contact),
        .contact_supported (contact_supported),
        .linked            (linked),
        .fresh             (fresh),
        .sample_taken      (sample_taken)
    );

endmodule

`default_nettype wire
